// File: design/ias_pkg.sv
`timescale 1ns / 1ps
// Package for the interval activity selection block: default sizes, result
// width and the command/status structs between controller and datapath.
// No dependencies.
package ias_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int TIME_BITS     = 16;
  localparam int RES_W         = 7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic insert;     // one insertion step into the sorted memory
    logic scan_init;  // clear the selection state
    logic scan;       // issue one read of the greedy scan
    logic emit_init;  // rewind for the emit sweep
    logic emit;       // test one arrival position for output
    logic close;      // end of set: clear fill count and drop flag
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;       // no room for another interval
    logic ins_done;   // current insertion step writes the new entry
    logic scan_end;   // scan read at the last loaded position
    logic emit_end;   // emit sweep at the last loaded position
  } sts_t;

endpackage

// File: design/ias_ctrl.sv
`timescale 1ns / 1ps
// Controller of the interval activity selection block: sequences load,
// insertion, greedy scan and emit. Depends on ias_pkg.
module ias_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last_interval,
  input  ias_pkg::sts_t sts,
  output ias_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN_INIT,
    S_SCAN,
    S_SCAN_TAIL,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   last_q;
  logic   accept;

  assign accept = (state == S_IDLE) && start && !busy;

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.insert    = (state == S_INSERT);
    cmd.scan_init = (state == S_SCAN_INIT);
    cmd.scan      = (state == S_SCAN);
    cmd.emit_init = (state == S_SCAN_TAIL);
    cmd.emit      = (state == S_EMIT);
    cmd.close     = (state == S_EMIT) && sts.emit_end;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!sts.full) begin
            state_next = S_INSERT;
          end else if (last_interval) begin
            state_next = S_SCAN_INIT;
          end
        end
      end
      S_INSERT: begin
        if (sts.ins_done) begin
          state_next = last_q ? S_SCAN_INIT : S_IDLE;
        end
      end
      S_SCAN_INIT: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: state_next = S_EMIT;
      S_EMIT: begin
        if (sts.emit_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      if (accept) begin
        last_q <= last_interval;
      end
    end
  end

endmodule

// File: design/ias_datapath.sv
`timescale 1ns / 1ps
// Datapath of the interval activity selection block: sorted interval memory,
// insertion compare, greedy selection mask and result registers.
// Depends on ias_pkg.
module ias_datapath #(
  parameter int MAX_INTERVALS = ias_pkg::MAX_INTERVALS,
  parameter int TIME_BITS     = ias_pkg::TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ias_pkg::cmd_t                  cmd,
  input  logic [TIME_BITS-1:0]           start_time,
  input  logic [TIME_BITS-1:0]           end_time,
  output ias_pkg::sts_t                  sts,
  output logic                           valid,
  output logic [ias_pkg::RES_W-1:0]      chosen_number,
  output logic [ias_pkg::RES_W-1:0]      chosen_count,
  output logic                           dropped_some,
  output logic                           last_result
);

  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int KW = 2 * TIME_BITS + IW;

  // Entry layout: {end, start, arrival index}; kept sorted by (end, start, arrival)
  logic [KW-1:0] sort_mem [MAX_INTERVALS];
  logic [KW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [KW-1:0] wr_data;

  logic [CW-1:0] load_cnt;
  logic [CW-1:0] cnt_m1;
  logic          ovf;
  logic [KW-1:0] new_entry;
  logic [IW-1:0] pos;
  logic [IW-1:0] idx;
  logic [IW-1:0] last_pos;
  logic [IW-1:0] fill_pos;

  logic [MAX_INTERVALS-1:0] mask;
  logic [CW-1:0]            count;
  logic [CW-1:0]            emitted;
  logic [CW-1:0]            emitted_inc;
  logic                     have_last;
  logic [TIME_BITS-1:0]     last_end;
  logic                     scan_vld;

  logic [TIME_BITS-1:0] rd_end;
  logic [TIME_BITS-1:0] rd_start;
  logic [IW-1:0]        rd_idx;
  logic [TIME_BITS-1:0] new_end;
  logic [TIME_BITS-1:0] new_start;
  logic                 full;
  logic                 sorts_after;
  logic                 shift;
  logic                 take;

  assign rd_end    = rd_data[KW-1 -: TIME_BITS];
  assign rd_start  = rd_data[IW +: TIME_BITS];
  assign rd_idx    = rd_data[IW-1:0];
  assign new_end   = new_entry[KW-1 -: TIME_BITS];
  assign new_start = new_entry[IW +: TIME_BITS];

  assign full        = (load_cnt == CW'(MAX_INTERVALS));
  assign fill_pos    = load_cnt[IW-1:0];
  assign cnt_m1      = load_cnt - CW'(1);
  assign last_pos    = cnt_m1[IW-1:0];
  assign emitted_inc = emitted + CW'(1);

  assign sorts_after = (rd_end != new_end) ? (rd_end > new_end) : (rd_start > new_start);
  assign shift       = (pos != '0) && sorts_after;
  assign take        = !have_last || (rd_start >= last_end);

  always_comb begin
    sts          = '0;
    sts.full     = full;
    sts.ins_done = !shift;
    sts.scan_end = (idx == last_pos);
    sts.emit_end = (idx == last_pos);
  end

  // Read one step ahead: the neighbour below during insertion, the scan slot otherwise
  always_comb begin
    if (cmd.accept) begin
      rd_addr = fill_pos - IW'(1);
    end else if (cmd.insert) begin
      rd_addr = pos - IW'(2);
    end else begin
      rd_addr = idx;
    end
  end

  assign wr_en   = cmd.insert;
  assign wr_addr = pos;
  assign wr_data = shift ? rd_data : new_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sort_mem[wr_addr] <= wr_data;
    end
    rd_data <= sort_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt  <= '0;
      ovf       <= 1'b0;
      pos       <= '0;
      idx       <= '0;
      mask      <= '0;
      count     <= '0;
      emitted   <= '0;
      have_last <= 1'b0;
      scan_vld  <= 1'b0;
      valid     <= 1'b0;
    end else begin
      scan_vld <= cmd.scan;
      valid    <= cmd.emit && mask[idx];
      if (cmd.accept) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          pos <= fill_pos;
        end
      end
      if (cmd.insert) begin
        if (shift) begin
          pos <= pos - IW'(1);
        end else begin
          load_cnt <= load_cnt + CW'(1);
        end
      end
      if (cmd.scan_init) begin
        mask      <= '0;
        count     <= '0;
        have_last <= 1'b0;
        idx       <= '0;
      end
      if (cmd.scan) begin
        idx <= idx + IW'(1);
      end
      if (scan_vld && take) begin
        mask[rd_idx] <= 1'b1;
        have_last    <= 1'b1;
        count        <= count + CW'(1);
      end
      if (cmd.emit_init) begin
        idx     <= '0;
        emitted <= '0;
      end
      if (cmd.emit) begin
        idx <= idx + IW'(1);
        if (mask[idx]) begin
          emitted <= emitted_inc;
        end
      end
      if (cmd.close) begin
        load_cnt <= '0;
        ovf      <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      new_entry <= {end_time, start_time, fill_pos};
    end
    if (scan_vld && take) begin
      last_end <= rd_end;
    end
    if (cmd.emit && mask[idx]) begin
      chosen_number <= ias_pkg::RES_W'(idx) + ias_pkg::RES_W'(1);
      chosen_count  <= ias_pkg::RES_W'(count);
      dropped_some  <= ovf;
      last_result   <= (emitted_inc == count);
    end
  end

endmodule

// File: design/interval_activity_selection.sv
`timescale 1ns / 1ps
// Interval activity selection, earliest finish first: top level.
// Joins ias_ctrl and ias_datapath; depends on ias_pkg.
//
// Usage: present start_time, end_time and last_interval with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Each interval is placed into a memory kept sorted by (end, start, arrival)
// with one shift per cycle, the block staying busy until the new entry is
// written. Once MAX_INTERVALS intervals are held, further ones are dropped
// and dropped_some is reported.
// The interval with last_interval high closes the set: after its insertion a
// greedy scan reads the L loaded entries, one memory read per cycle, and an
// emit sweep walks the L arrival positions of the selection mask.
// Each chosen interval appears for one cycle with valid high, in ascending
// chosen_number, together with chosen_count and dropped_some; last_result
// marks the final one.
// The receiver cannot stall: every result must be taken in its valid cycle.
// Synchronous reset empties the set, clears the drop flag and idles the block.
module interval_activity_selection #(
  parameter int MAX_INTERVALS = ias_pkg::MAX_INTERVALS,
  parameter int TIME_BITS     = ias_pkg::TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [TIME_BITS-1:0]      start_time,
  input  logic [TIME_BITS-1:0]      end_time,
  input  logic                      last_interval,
  output logic                      valid,
  output logic [ias_pkg::RES_W-1:0] chosen_number,
  output logic [ias_pkg::RES_W-1:0] chosen_count,
  output logic                      dropped_some,
  output logic                      last_result
);

  ias_pkg::cmd_t cmd;
  ias_pkg::sts_t sts;

  ias_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .last_interval (last_interval),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy)
  );

  ias_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .start_time    (start_time),
    .end_time      (end_time),
    .sts           (sts),
    .valid         (valid),
    .chosen_number (chosen_number),
    .chosen_count  (chosen_count),
    .dropped_some  (dropped_some),
    .last_result   (last_result)
  );

endmodule

// File: design/ias_checker.sv
`timescale 1ns / 1ps
// Port-level checks for interval_activity_selection, attached by bind.
// Depends on ias_pkg for the result width.
module ias_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      last_interval,
  input logic                      valid,
  input logic [ias_pkg::RES_W-1:0] chosen_number,
  input logic [ias_pkg::RES_W-1:0] chosen_count,
  input logic                      last_result
);

  // A closing transaction always starts a selection run
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_interval |=> busy)
    else $error("closing transaction did not raise busy");

  // Results come only out of a run
  a_valid_after_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result without a preceding run");

  // Numbers and counts are 1-based
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    valid |-> (chosen_number != '0) && (chosen_count != '0))
    else $error("zero chosen_number or chosen_count");

  // The final result ends the run's output
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    valid && last_result |=> !valid)
    else $error("result after the final one");

endmodule

bind interval_activity_selection ias_checker u_ias_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .last_interval (last_interval),
  .valid         (valid),
  .chosen_number (chosen_number),
  .chosen_count  (chosen_count),
  .last_result   (last_result)
);
